/* hdl/level_of_detail_selector_assert.svh */
// assertion macros for the level of detail selector
`ifndef LEVEL_OF_DETAIL_SELECTOR_ASSERT_SVH
`define LEVEL_OF_DETAIL_SELECTOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define LOD_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define LOD_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define LOD_ASSERT_IMP(label, clk, rst, a, c)
`define LOD_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

/* hdl/lod_pkg.sv */
`timescale 1ns / 1ps
package lod_pkg;
  localparam int NumRegs = 8;
  localparam int CfgIdxBits = 3;
  localparam int CfgDataBits = 51;
  localparam logic [1:0] LevelCoarse = 2'd0;
  localparam logic [1:0] LevelMedium = 2'd1;
  localparam logic [1:0] LevelFine = 2'd2;
  localparam logic [16:0] QualityOne = 17'd65536;

  typedef enum logic [2:0] {
    REG_FAR = 3'd0, REG_NEAR = 3'd1, REG_TARGET = 3'd2, REG_QUALITY = 3'd3,
    REG_PERIOD = 3'd4, REG_ADAPTIVE = 3'd5, REG_COSTS = 3'd6, REG_ACCS = 3'd7
  } reg_idx_t;
endpackage

/* hdl/lod_front.sv */
`timescale 1ns / 1ps
// accepts frames, forms the squared distance with one shared multiplier,
// and pushes the job into a two-entry queue
module lod_front import lod_pkg::*; #(
  parameter int PB = 24,
  parameter int TB = 16,
  parameter int JW = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [PB-1:0] vx, vy, vz, ox, oy, oz,
  input  logic [TB-1:0] ft,
  output logic q_valid,
  input  logic q_ready,
  output logic [JW-1:0] q_data
);
  typedef enum logic [1:0] {F_IDLE, F_MUL, F_PUSH} fst_t;
  fst_t st;
  logic [1:0] k;
  logic [PB:0] d [3];
  logic [2*PB+3:0] acc;
  logic [TB-1:0] ftr;
  logic [2*PB+1:0] prod;
  logic [JW-1:0] ent [2];
  logic wp, rp;
  logic [1:0] cnt;
  logic push;

  assign prod = d[k] * d[k];
  assign push = (st == F_PUSH) && (cnt != 2'd2);
  assign in_ready = (st == F_IDLE);
  assign q_valid = (cnt != 2'd0);
  assign q_data = ent[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= F_IDLE;
      k <= 2'd0;
    end else begin
      unique case (st)
        F_IDLE: if (in_valid) begin
          st <= F_MUL;
          k <= 2'd0;
        end
        F_MUL: if (k == 2'd2) st <= F_PUSH; else k <= k + 2'd1;
        F_PUSH: if (push) st <= F_IDLE;
        default: st <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (st == F_IDLE && in_valid) begin
      d[0] <= (vx > ox) ? (PB+1)'($signed({vx[PB-1], vx}) - $signed({ox[PB-1], ox}))
                        : (PB+1)'($signed({ox[PB-1], ox}) - $signed({vx[PB-1], vx}));
      d[1] <= (vy > oy) ? (PB+1)'($signed({vy[PB-1], vy}) - $signed({oy[PB-1], oy}))
                        : (PB+1)'($signed({oy[PB-1], oy}) - $signed({vy[PB-1], vy}));
      d[2] <= (vz > oz) ? (PB+1)'($signed({vz[PB-1], vz}) - $signed({oz[PB-1], oz}))
                        : (PB+1)'($signed({oz[PB-1], oz}) - $signed({vz[PB-1], vz}));
      ftr <= ft;
      acc <= '0;
    end else if (st == F_MUL) begin
      acc <= acc + (2*PB+4)'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent[wp] <= {ftr, acc};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (q_valid && q_ready) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, q_valid && q_ready};
    end
  end
endmodule

/* hdl/lod_back.sv */
`timescale 1ns / 1ps
// evaluates one job: threshold compares, time level, switch test, average
module lod_back import lod_pkg::*; #(
  parameter int PB = 24,
  parameter int TB = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [CfgIdxBits-1:0] cfg_idx,
  input  logic [CfgDataBits-1:0] cfg_data,
  input  logic q_valid,
  output logic q_ready,
  input  logic [2*PB+4+TB-1:0] q_data,
  output logic o_valid,
  input  logic o_ready,
  output logic [TB+35:0] o_data
);
  localparam int DW = 2*PB+4;
  localparam int RS = TB + 8;
  localparam logic [RS-4:0] RECIP10 = (RS-3)'((64'd1 << RS) / 64'd10 + 64'd1);
  typedef enum logic [3:0] {
    B_IDLE, B_MOD, B_CMP, B_M1, B_M2, B_M3, B_DEC, B_AVG, B_OUT
  } bst_t;
  bst_t st;
  logic [PB-1:0] far_d, near_d;
  logic [TB-1:0] tgt;
  logic [16:0] qw;
  logic [15:0] per;
  logic adapt;
  logic [50:0] costs;
  logic [47:0] accs;
  logic [1:0] cur;
  logic [31:0] fcnt, chg;
  logic pend;
  logic [TB-1:0] avg;
  logic [DW-1:0] dsq;
  logic [TB-1:0] ftv;
  logic eval, chgd, over15, over12;
  logic [1:0] cand;
  logic [2*PB-1:0] far2, near2;
  logic signed [17:0] dcost, dacc;
  logic signed [16:0] cc, cn, ac, an;
  logic [16:0] qsat, qf;
  logic signed [35:0] l1, r1;
  logic signed [52:0] lhs, rhs;
  logic [1:0] ml;
  logic signed [35:0] ma;
  logic signed [17:0] mb;
  logic signed [53:0] mp;
  logic [TB+4:0] sum;
  logic [2*TB+9:0] qprod;
  logic [TB-1:0] quo;
  logic [4:0] mbit;
  logic [15:0] rem;
  logic [16:0] rsh;
  logic [15:0] perx;

  function automatic logic [16:0] pick16(logic [47:0] w, logic [1:0] l);
    case (l)
      2'd0: return {1'b0, w[15:0]};
      2'd1: return {1'b0, w[31:16]};
      default: return {1'b0, w[47:32]};
    endcase
  endfunction

  assign ma = (ml == 2'd0) ? 36'(dcost) : (ml == 2'd1) ? 36'(dacc) : ((ml == 2'd2) ? l1 : r1);
  assign mb = (ml == 2'd0) ? 18'(ac) : (ml == 2'd1) ? 18'(cc) :
              ((ml == 2'd2) ? 18'sd65536 : 18'(qf));
  assign mp = ma * mb;
  assign qsat = (qw > QualityOne) ? QualityOne : qw;
  assign qf = (cand < cur) ? (QualityOne - qsat) : qsat;
  assign sum = (TB+5)'(ftv) + (TB+5)'(avg) * (TB+5)'(9) + (TB+5)'(5);
  assign qprod = (2*TB+10)'(sum) * (2*TB+10)'(RECIP10);
  assign quo = TB'(qprod >> RS);
  assign perx = (per == '0) ? 16'd1 : per;
  assign rsh = {rem, fcnt[mbit]};
  assign q_ready = (st == B_IDLE);
  assign o_valid = (st == B_OUT);
  assign o_data = {chg, avg, eval, chgd, cur};

  always_ff @(posedge clk) begin
    if (rst) begin
      far_d <= '0; near_d <= '0; tgt <= TB'(4267); qw <= 17'd32768;
      per <= 16'd1; adapt <= 1'b0; costs <= '0; accs <= '0;
      pend <= 1'b0; cur <= LevelMedium; fcnt <= '0; chg <= '0; avg <= '0;
      st <= B_IDLE;
    end else begin
      if (cfg_we) begin
        pend <= 1'b1;
        unique case (reg_idx_t'(cfg_idx))
          REG_FAR: far_d <= cfg_data[PB-1:0];
          REG_NEAR: near_d <= cfg_data[PB-1:0];
          REG_TARGET: tgt <= cfg_data[TB-1:0];
          REG_QUALITY: qw <= cfg_data[16:0];
          REG_PERIOD: per <= cfg_data[15:0];
          REG_ADAPTIVE: adapt <= cfg_data[0];
          REG_COSTS: costs <= cfg_data[50:0];
          REG_ACCS: accs <= cfg_data[47:0];
          default: pend <= pend;
        endcase
      end
      unique case (st)
        B_IDLE: if (q_valid) begin
          dsq <= q_data[DW-1:0];
          ftv <= q_data[DW+TB-1:DW];
          fcnt <= fcnt + 32'd1;
          rem <= '0;
          mbit <= 5'd31;
          st <= B_MOD;
        end
        // frame count modulo the period, one bit per cycle
        B_MOD: begin
          rem <= (rsh >= {1'b0, perx}) ? 16'(rsh - {1'b0, perx}) : rsh[15:0];
          if (mbit == 5'd0) st <= B_CMP;
          else mbit <= mbit - 5'd1;
        end
        B_CMP: begin
          over15 <= ({1'b0, ftv} << 1) > ({2'b0, tgt} + {1'b0, tgt, 1'b0});
          over12 <= ({3'b0, ftv} + {1'b0, ftv, 2'b0}) > ({2'b0, tgt, 1'b0} + {1'b0, tgt, 2'b0});
          far2 <= far_d * far_d;
          near2 <= near_d * near_d;
          st <= B_M1;
        end
        B_M1: begin
          eval <= (rem == '0) || pend || (adapt && over15);
          cand <= (dsq > DW'(far2)) ? LevelCoarse :
                  (dsq > DW'(near2)) ? LevelMedium : LevelFine;
          st <= B_M2;
        end
        B_M2: begin
          if (adapt && ftv != '0) begin
            if (over15) cand <= LevelCoarse;
            else if (over12 && cand == LevelFine) cand <= LevelMedium;
          end
          st <= B_M3;
          ml <= 2'd0;
        end
        B_M3: begin
          if (ml == 2'd0) l1 <= mp[35:0];
          if (ml == 2'd1) r1 <= mp[35:0];
          if (ml == 2'd2) lhs <= mp[52:0];
          if (ml == 2'd3) begin
            rhs <= mp[52:0];
            st <= B_DEC;
          end
          ml <= ml + 2'd1;
        end
        B_DEC: begin
          chgd <= 1'b0;
          if (eval) begin
            pend <= 1'b0;
            if (cand != cur && cur != 2'd3 && costs[48+cur] && costs[48+cand] &&
                ((cand < cur) ? (lhs > rhs) : (lhs < rhs))) begin
              cur <= cand;
              chg <= chg + 32'd1;
              chgd <= 1'b1;
            end
          end
          st <= B_AVG;
        end
        B_AVG: begin
          if (ftv != '0) avg <= (avg == '0) ? ftv : quo;
          st <= B_OUT;
        end
        B_OUT: if (o_ready) st <= B_IDLE;
        default: st <= B_IDLE;
      endcase
    end
  end

  // operand prep for the switch test
  assign cc = pick16(costs[47:0], cur);
  assign ac = pick16(accs, cur);
  assign cn = pick16(costs[47:0], cand);
  assign an = pick16(accs, cand);

  // coarser: (cc-cn)*ac*1 vs (ac-an)*cc*(1-q); finer: (cn-cc)*ac vs (an-ac)*cc*q
  always_comb begin
    dcost = (cand < cur) ? (18'(cc) - 18'(cn)) : (18'(cn) - 18'(cc));
    dacc = (cand < cur) ? (18'(ac) - 18'(an)) : (18'(an) - 18'(ac));
  end
endmodule

/* hdl/level_of_detail_selector.sv */
`timescale 1ns / 1ps
// Level of detail selector. One frame transaction in gives one result
// transaction out. The front end forms the squared viewer-object distance
// on one shared multiplier and queues the job in a two-entry queue; the
// back end works out a 32-step remainder of the frame count by the update
// period, then does the threshold compares, a four-step multiply sequence
// for the cost/accuracy switch test and the running average. The front end
// can take the next frame while the back end is still busy with the last;
// the back end takes a new job only after its result has gone out. A stalled
// result holds the back end and, once the queue is full, the input. Register
// writes take effect at once and must be made while no frame is in flight.
`include "level_of_detail_selector_assert.svh"
module level_of_detail_selector import lod_pkg::*; #(
  parameter int POSITION_BITS = 24,
  parameter int TIME_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // viewer_x, viewer_y, viewer_z, object_x, object_y, object_z, frame_time
  input  logic [((6*POSITION_BITS+TIME_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // level, changed, evaluated, average_time, change_count
  output logic [((TIME_BITS+36+7)/8)*8-1:0] m_axis_tdata,
  input  logic cfg_we,
  input  logic [CfgIdxBits-1:0] cfg_idx,
  input  logic [CfgDataBits-1:0] cfg_data
);
  localparam int PB = POSITION_BITS;
  localparam int JW = 2*PB+4+TIME_BITS;
  localparam int OW = ((TIME_BITS+36+7)/8)*8;
  logic qv, qr;
  logic [JW-1:0] qd;
  logic [TIME_BITS+35:0] od;

  lod_front #(.PB(PB), .TB(TIME_BITS), .JW(JW)) u_front (
    .clk, .rst, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .vx(s_axis_tdata[PB-1:0]), .vy(s_axis_tdata[2*PB-1:PB]),
    .vz(s_axis_tdata[3*PB-1:2*PB]), .ox(s_axis_tdata[4*PB-1:3*PB]),
    .oy(s_axis_tdata[5*PB-1:4*PB]), .oz(s_axis_tdata[6*PB-1:5*PB]),
    .ft(s_axis_tdata[6*PB+TIME_BITS-1:6*PB]),
    .q_valid(qv), .q_ready(qr), .q_data(qd)
  );

  lod_back #(.PB(PB), .TB(TIME_BITS)) u_back (
    .clk, .rst, .cfg_we, .cfg_idx, .cfg_data,
    .q_valid(qv), .q_ready(qr), .q_data(qd),
    .o_valid(m_axis_tvalid), .o_ready(m_axis_tready), .o_data(od)
  );

  assign m_axis_tdata = OW'(od);

  `LOD_ASSERT_IMP(a_level_legal, clk, rst, m_axis_tvalid, m_axis_tdata[1:0] != 2'd3)
  `LOD_ASSERT_IMP(a_chg_eval, clk, rst, m_axis_tvalid && m_axis_tdata[2], m_axis_tdata[3])
  `LOD_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
endmodule
